[hw/rtl/gaps_pkg.sv]
// ============================================================================
// gaps_pkg
// Shared constants, types and a helper function of the grid path search block.
// ============================================================================
package gaps_pkg;

    // Grid geometry: cell index is {y, x}
    localparam int GRID_W     = 16;
    localparam int GRID_H     = 16;
    localparam int COORD_W    = 4;
    localparam int CELL_W     = 8;
    localparam int NCELL      = GRID_W * GRID_H;

    // Costs and keys
    localparam int COST_W     = 10;
    localparam int H_W        = 5;
    localparam int F_W        = 11;
    localparam int KEY_W      = F_W + CELL_W;
    localparam int ENT_W      = KEY_W + COST_W;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Trace limit register
    localparam int LIM_W      = 6;
    localparam int MAX_TRACE  = 63;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(63);

    // Default open list depth
    localparam int HEAP_DEPTH = 1024;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Cell status codes
    localparam logic [1:0] STAT_SMOKE = 2'd1;
    localparam logic [1:0] STAT_FIRE  = 2'd2;

    // Direction a cell was entered from
    localparam logic [1:0] DIR_FROM_WEST  = 2'd0;
    localparam logic [1:0] DIR_FROM_EAST  = 2'd1;
    localparam logic [1:0] DIR_FROM_NORTH = 2'd2;
    localparam logic [1:0] DIR_FROM_SOUTH = 2'd3;

    // Result kinds
    localparam logic [1:0] OUT_SAME  = 2'd0;
    localparam logic [1:0] OUT_FAIL  = 2'd1;
    localparam logic [1:0] OUT_TRACE = 2'd2;
    localparam logic [1:0] OUT_START = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       cell_wr;
        logic       load_query;
        logic       clr_step;
        logic       push_init;
        logic       push_start;
        logic       heap_wr_ent;
        logic       rd_parent;
        logic       up_step;
        logic       rd_top;
        logic       pop_start;
        logic       rd_last;
        logic       load_last;
        logic       rd_left;
        logic       rd_right;
        logic       dn_step;
        logic       dir_rd;
        logic       dir_next;
        logic       nb_rd;
        logic       relax_upd;
        logic       succ;
        logic       prev_rd;
        logic       tr_step;
        logic       out_load;
        logic [1:0] out_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic s_eq_g;
        logic clr_last;
        logic out_free;
        logic heap_full;
        logic up_root;
        logic up_ge;
        logic heap_empty;
        logic heap_one;
        logic top_is_goal;
        logic l_out;
        logic dn_move;
        logic dir_done;
        logic nb_ok;
        logic better;
        logic tr_done;
    } t_sts;

    // Manhattan distance between two cells
    function automatic logic [H_W-1:0] heur(input logic [CELL_W-1:0] a,
                                            input logic [CELL_W-1:0] b);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        dx = (a[COORD_W-1:0] > b[COORD_W-1:0]) ? a[COORD_W-1:0] - b[COORD_W-1:0]
                                                 : b[COORD_W-1:0] - a[COORD_W-1:0];
        dy = (a[CELL_W-1:COORD_W] > b[CELL_W-1:COORD_W])
           ? a[CELL_W-1:COORD_W] - b[CELL_W-1:COORD_W]
           : b[CELL_W-1:COORD_W] - a[CELL_W-1:COORD_W];
        return H_W'(dx) + H_W'(dy);
    endfunction

endpackage

[hw/rtl/gaps_ram.sv]
// ============================================================================
// gaps_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ============================================================================
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/gaps_dp.sv]
// ============================================================================
// gaps_dp
// Search datapath: grid store, cost, mark and trace memories, open list heap,
// expansion registers, trace walker and result register.
// ============================================================================
module gaps_dp #(
    parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gaps_pkg::t_cmd             i_cmd,
    output gaps_pkg::t_sts             o_sts,
    input  logic [31:0]                i_req_data,
    input  logic                       i_cfg_wr_en,
    input  logic [gaps_pkg::LIM_W-1:0] i_cfg_wr_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [23:0]                o_res_data,
    output logic                       o_res_last
);
    import gaps_pkg::*;

    localparam int HA = $clog2(HEAP_DEPTH);
    localparam int NW = HA + 1;
    localparam int CW = HA + 2;

    // Request fields
    logic [COORD_W-1:0] req_cx, req_cy, req_sx, req_sy, req_gx, req_gy;
    logic [1:0]         req_stat;
    logic               req_we, req_ws, req_smoke;

    assign req_cx    = i_req_data[3:0];
    assign req_cy    = i_req_data[7:4];
    assign req_stat  = i_req_data[9:8];
    assign req_we    = i_req_data[10];
    assign req_ws    = i_req_data[11];
    assign req_sx    = i_req_data[15:12];
    assign req_sy    = i_req_data[19:16];
    assign req_gx    = i_req_data[23:20];
    assign req_gy    = i_req_data[27:24];
    assign req_smoke = i_req_data[28];

    // Registers
    logic [LIM_W-1:0]  r_trace_limit;
    logic [CELL_W-1:0] r_s, r_g, r_c, r_nb, r_t, r_clr;
    logic              r_smoke, r_inb, r_wbit, r_cv;
    logic [COST_W-1:0] r_cc, r_total;
    logic [NW-1:0]     r_n;
    logic [HA-1:0]     r_i;
    logic [ENT_W-1:0]  r_ent, r_left;
    logic [2:0]        r_dir;
    logic [LIM_W-1:0]  r_k, r_lim;
    logic [NCELL-1:0]  r_cell_valid;
    logic              r_out_valid, r_out_found, r_out_last;
    logic [COST_W-1:0] r_out_cost;
    logic [CELL_W-1:0] r_out_tile;

    // Memory ports
    logic              cell_wr_en, cell_rd_en;
    logic [CELL_W-1:0] cell_wr_addr, cell_rd_addr;
    logic [3:0]        cell_wr_data, cell_rdata;
    logic              best_rd_en;
    logic [COST_W-1:0] best_rdata;
    logic [1:0]        prev_rdata;
    logic              flag_wr_en;
    logic [CELL_W-1:0] flag_wr_addr;
    logic [1:0]        flag_wr_data, flag_rdata;
    logic              heap_wr_en, heap_rd_en;
    logic [HA-1:0]     heap_wr_addr, heap_rd_addr;
    logic [ENT_W-1:0]  heap_wr_data, heap_rdata;

    // Combinational helpers
    logic [CW-1:0]     left_idx, right_idx;
    logic [HA-1:0]     parent_idx;
    logic [COORD_W-1:0] cx, cy, tx, ty;
    logic              dir_inb, dir_wbit;
    logic [CELL_W-1:0] dir_nb, dir_wcell, t_next;
    logic [1:0]        nb_stat;
    logic [COST_W+1:0] cost_raw;
    logic [COST_W-1:0] cost_new;
    logic [F_W-1:0]    f_new;
    logic              right_ok, l_less, pick_right, dn_move;
    logic [ENT_W-1:0]  child_ent;
    logic [HA-1:0]     child_idx;
    logic [LIM_W-1:0]  lim_clamped;

    assign left_idx   = {1'b0, r_i, 1'b1};
    assign right_idx  = left_idx + CW'(1);
    assign parent_idx = (r_i - HA'(1)) >> 1;

    assign cx = r_c[COORD_W-1:0];
    assign cy = r_c[CELL_W-1:COORD_W];
    assign tx = r_t[COORD_W-1:0];
    assign ty = r_t[CELL_W-1:COORD_W];

    // Neighbor, its bound check and the cell that carries the wall
    always_comb begin
        dir_inb   = 1'b0;
        dir_nb    = r_c;
        dir_wcell = r_c;
        dir_wbit  = 1'b0;
        case (r_dir[1:0])
            DIR_FROM_WEST: begin
                dir_inb = (cx != COORD_W'(GRID_W - 1));
                dir_nb  = r_c + CELL_W'(1);
            end
            DIR_FROM_EAST: begin
                dir_inb   = (cx != '0);
                dir_nb    = r_c - CELL_W'(1);
                dir_wcell = r_c - CELL_W'(1);
            end
            DIR_FROM_NORTH: begin
                dir_inb  = (cy != COORD_W'(GRID_H - 1));
                dir_nb   = r_c + CELL_W'(GRID_W);
                dir_wbit = 1'b1;
            end
            DIR_FROM_SOUTH: begin
                dir_inb   = (cy != '0);
                dir_nb    = r_c - CELL_W'(GRID_W);
                dir_wcell = r_c - CELL_W'(GRID_W);
                dir_wbit  = 1'b1;
            end
            default: begin
                dir_inb = 1'b0;
            end
        endcase
    end

    // Relaxation cost with surcharges, saturating
    assign nb_stat  = r_cv ? cell_rdata[1:0] : 2'd0;
    assign cost_raw = (COST_W+2)'(r_cc) + (COST_W+2)'(1)
                    + (COST_W+2)'(nb_stat == STAT_FIRE)
                    + (COST_W+2)'(r_smoke && (nb_stat == STAT_SMOKE));
    assign cost_new = (cost_raw > (COST_W+2)'(COST_MAX)) ? COST_MAX : cost_raw[COST_W-1:0];
    assign f_new    = F_W'(cost_new) + F_W'(heur(r_nb, r_g));

    // Sift-down child choice: left latched, right on read data
    assign right_ok = ({1'b0, right_idx} < {2'b0, r_n});
    assign l_less   = r_left[ENT_W-1:COST_W] < r_ent[ENT_W-1:COST_W];
    always_comb begin
        pick_right = 1'b0;
        if (right_ok) begin
            if (l_less) begin
                pick_right = heap_rdata[ENT_W-1:COST_W] < r_left[ENT_W-1:COST_W];
            end else begin
                pick_right = heap_rdata[ENT_W-1:COST_W] < r_ent[ENT_W-1:COST_W];
            end
        end
    end
    assign dn_move   = l_less || pick_right;
    assign child_ent = pick_right ? heap_rdata : r_left;
    assign child_idx = pick_right ? right_idx[HA-1:0] : left_idx[HA-1:0];

    // Trace step along the stored entry direction
    always_comb begin
        t_next = r_t;
        case (prev_rdata)
            DIR_FROM_WEST:  if (tx != '0) t_next = r_t - CELL_W'(1);
            DIR_FROM_EAST:  if (tx != COORD_W'(GRID_W - 1)) t_next = r_t + CELL_W'(1);
            DIR_FROM_NORTH: if (ty != '0) t_next = r_t - CELL_W'(GRID_W);
            DIR_FROM_SOUTH: if (ty != COORD_W'(GRID_H - 1)) t_next = r_t + CELL_W'(GRID_W);
            default:        t_next = r_t;
        endcase
    end

    assign lim_clamped = (r_trace_limit == '0) ? LIM_W'(1)
                       : (r_trace_limit > LIM_W'(MAX_TRACE)) ? LIM_W'(MAX_TRACE)
                       : r_trace_limit;

    // Grid store: status in [1:0], east wall [2], south wall [3]
    assign cell_wr_en   = i_cmd.cell_wr;
    assign cell_wr_addr = {req_cy, req_cx};
    assign cell_wr_data = {req_ws, req_we, req_stat};
    assign cell_rd_en   = i_cmd.dir_rd | i_cmd.nb_rd;
    assign cell_rd_addr = i_cmd.dir_rd ? dir_wcell : r_nb;

    gaps_ram #(.WIDTH(4), .DEPTH(NCELL)) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cell_wr_en),
        .i_wr_addr (cell_wr_addr),
        .i_wr_data (cell_wr_data),
        .i_rd_en   (cell_rd_en),
        .i_rd_addr (cell_rd_addr),
        .o_rd_data (cell_rdata)
    );

    // Best cost per cell
    assign best_rd_en = i_cmd.nb_rd;
    gaps_ram #(.WIDTH(COST_W), .DEPTH(NCELL)) u_best_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.relax_upd),
        .i_wr_addr (r_nb),
        .i_wr_data (cost_new),
        .i_rd_en   (best_rd_en),
        .i_rd_addr (r_nb),
        .o_rd_data (best_rdata)
    );

    // Entry direction per cell
    gaps_ram #(.WIDTH(2), .DEPTH(NCELL)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.relax_upd),
        .i_wr_addr (r_nb),
        .i_wr_data (r_dir[1:0]),
        .i_rd_en   (i_cmd.prev_rd),
        .i_rd_addr (r_t),
        .o_rd_data (prev_rdata)
    );

    // Per-cell marks: expanded in [1], cost set in [0]; cleared cell by cell
    // before each search, a pop marks both, an update marks cost set only
    always_comb begin
        flag_wr_en   = i_cmd.clr_step | i_cmd.pop_start | i_cmd.relax_upd;
        flag_wr_addr = r_clr;
        flag_wr_data = 2'b00;
        if (i_cmd.pop_start) begin
            flag_wr_addr = heap_rdata[COST_W +: CELL_W];
            flag_wr_data = 2'b11;
        end else if (i_cmd.relax_upd) begin
            flag_wr_addr = r_nb;
            flag_wr_data = 2'b01;
        end
    end

    gaps_ram #(.WIDTH(2), .DEPTH(NCELL)) u_flag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (flag_wr_en),
        .i_wr_addr (flag_wr_addr),
        .i_wr_data (flag_wr_data),
        .i_rd_en   (i_cmd.dir_rd),
        .i_rd_addr (dir_nb),
        .o_rd_data (flag_rdata)
    );

    // Open list heap ports
    always_comb begin
        heap_wr_en   = i_cmd.heap_wr_ent | i_cmd.up_step | i_cmd.dn_step;
        heap_wr_addr = r_i;
        heap_wr_data = r_ent;
        if (i_cmd.up_step) begin
            heap_wr_data = heap_rdata;
        end else if (i_cmd.dn_step) begin
            heap_wr_data = child_ent;
        end
        heap_rd_en   = i_cmd.rd_parent | i_cmd.rd_top | i_cmd.rd_last
                     | i_cmd.rd_left | i_cmd.rd_right;
        heap_rd_addr = '0;
        if (i_cmd.rd_parent) begin
            heap_rd_addr = parent_idx;
        end else if (i_cmd.rd_last) begin
            heap_rd_addr = HA'(r_n - NW'(1));
        end else if (i_cmd.rd_left) begin
            heap_rd_addr = left_idx[HA-1:0];
        end else if (i_cmd.rd_right) begin
            heap_rd_addr = right_idx[HA-1:0];
        end
    end

    gaps_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (heap_wr_en),
        .i_wr_addr (heap_wr_addr),
        .i_wr_data (heap_wr_data),
        .i_rd_en   (heap_rd_en),
        .i_rd_addr (heap_rd_addr),
        .o_rd_data (heap_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_limit <= LIM_RESET;
            r_cell_valid  <= '0;
            r_n           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_trace_limit <= i_cfg_wr_data;
            end
            if (i_cmd.cell_wr) begin
                r_cell_valid[cell_wr_addr] <= 1'b1;
            end
            if (i_cmd.load_query) begin
                r_n <= '0;
            end
            if (i_cmd.push_start) begin
                r_n <= r_n + NW'(1);
            end
            if (i_cmd.pop_start) begin
                r_n <= r_n - NW'(1);
            end
            // Drop the result on accept, load a new one when asked
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_s     <= {req_sy, req_sx};
            r_g     <= {req_gy, req_gx};
            r_smoke <= req_smoke;
            r_clr   <= '0;
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + CELL_W'(1);
        end
        if (i_cmd.push_init) begin
            r_ent <= {F_W'(heur(r_s, r_g)), r_s, COST_W'(0)};
        end
        if (i_cmd.relax_upd) begin
            r_ent <= {f_new, r_nb, cost_new};
        end
        if (i_cmd.load_last) begin
            r_ent <= heap_rdata;
        end
        if (i_cmd.push_start) begin
            r_i <= r_n[HA-1:0];
        end
        if (i_cmd.up_step) begin
            r_i <= parent_idx;
        end
        if (i_cmd.load_last) begin
            r_i <= '0;
        end
        if (i_cmd.dn_step) begin
            r_i <= child_idx;
        end
        if (i_cmd.rd_right) begin
            r_left <= heap_rdata;
        end
        if (i_cmd.pop_start) begin
            r_c   <= heap_rdata[COST_W +: CELL_W];
            r_cc  <= heap_rdata[COST_W-1:0];
            r_dir <= '0;
        end
        if (i_cmd.dir_next) begin
            r_dir <= r_dir + 3'd1;
        end
        if (i_cmd.dir_rd) begin
            r_nb   <= dir_nb;
            r_inb  <= dir_inb;
            r_wbit <= dir_wbit;
        end
        if (cell_rd_en) begin
            r_cv <= r_cell_valid[cell_rd_addr];
        end
        if (i_cmd.succ) begin
            r_total <= heap_rdata[COST_W-1:0];
            r_t     <= r_g;
            r_k     <= '0;
            r_lim   <= lim_clamped;
        end
        if (i_cmd.tr_step) begin
            r_t <= t_next;
            r_k <= r_k + LIM_W'(1);
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OUT_SAME: begin
                    r_out_found <= 1'b1;
                    r_out_cost  <= '0;
                    r_out_tile  <= r_s;
                    r_out_last  <= 1'b1;
                end
                OUT_FAIL: begin
                    r_out_found <= 1'b0;
                    r_out_cost  <= '0;
                    r_out_tile  <= r_s;
                    r_out_last  <= 1'b1;
                end
                OUT_TRACE: begin
                    r_out_found <= 1'b1;
                    r_out_cost  <= r_total;
                    r_out_tile  <= r_t;
                    r_out_last  <= 1'b0;
                end
                default: begin
                    r_out_found <= 1'b1;
                    r_out_cost  <= r_total;
                    r_out_tile  <= r_s;
                    r_out_last  <= 1'b1;
                end
            endcase
        end
    end

    // Status to controller
    always_comb begin
        o_sts.s_eq_g      = (r_s == r_g);
        o_sts.clr_last    = (r_clr == CELL_W'(NCELL - 1));
        o_sts.out_free    = !r_out_valid || i_res_ready;
        o_sts.heap_full   = (r_n == NW'(HEAP_DEPTH));
        o_sts.up_root     = (r_i == '0);
        o_sts.up_ge       = r_ent[ENT_W-1:COST_W] >= heap_rdata[ENT_W-1:COST_W];
        o_sts.heap_empty  = (r_n == '0);
        o_sts.heap_one    = (r_n == NW'(1));
        o_sts.top_is_goal = (heap_rdata[COST_W +: CELL_W] == r_g);
        o_sts.l_out       = !({1'b0, left_idx} < {2'b0, r_n});
        o_sts.dn_move     = dn_move;
        o_sts.dir_done    = r_dir[2];
        o_sts.nb_ok       = r_inb && !(r_cv && cell_rdata[2 + {1'b0, r_wbit}])
                          && !flag_rdata[1];
        o_sts.better      = !flag_rdata[0] || (cost_new < best_rdata);
        o_sts.tr_done     = (r_t == r_s) || (r_k == r_lim);
    end

    assign o_res_valid = r_out_valid;
    assign o_res_data  = {5'd0, r_out_tile[CELL_W-1:COORD_W], r_out_tile[COORD_W-1:0],
                          r_out_cost, r_out_found};
    assign o_res_last  = r_out_last;

endmodule

[hw/rtl/gaps_ctrl.sv]
// ============================================================================
// gaps_ctrl
// Search controller: request intake, heap push and pop sequencing, neighbor
// relaxation and trace output.
// ============================================================================
module gaps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_kind,
    output logic           o_req_ready,
    output gaps_pkg::t_cmd o_cmd,
    input  gaps_pkg::t_sts i_sts
);
    import gaps_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_QSTART   = 5'd1;
    localparam logic [4:0] S_PUSH     = 5'd2;
    localparam logic [4:0] S_UP_CHK   = 5'd3;
    localparam logic [4:0] S_UP_CMP   = 5'd4;
    localparam logic [4:0] S_TOP_RD   = 5'd5;
    localparam logic [4:0] S_TOP_CHK  = 5'd6;
    localparam logic [4:0] S_DN_LAST  = 5'd7;
    localparam logic [4:0] S_DN_L     = 5'd8;
    localparam logic [4:0] S_DN_R     = 5'd9;
    localparam logic [4:0] S_DN_CMP   = 5'd10;
    localparam logic [4:0] S_DIR      = 5'd11;
    localparam logic [4:0] S_DIR_WALL = 5'd12;
    localparam logic [4:0] S_RELAX    = 5'd13;
    localparam logic [4:0] S_TR_CHK   = 5'd14;
    localparam logic [4:0] S_TR_EMIT  = 5'd15;
    localparam logic [4:0] S_TR_END   = 5'd16;
    localparam logic [4:0] S_FAIL     = 5'd17;
    localparam logic [4:0] S_CLEAR    = 5'd18;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            // Take a request: writes finish here, queries start a search
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_kind == REQ_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_QSTART;
                    end else begin
                        o_cmd.cell_wr = 1'b1;
                    end
                end
            end
            S_QSTART: begin
                if (i_sts.s_eq_g) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_SAME;
                        n_state        = S_IDLE;
                    end
                end else begin
                    n_state = S_CLEAR;
                end
            end
            // Clear the per-cell marks, then push the start cell
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.push_init = 1'b1;
                    n_ret           = S_TOP_RD;
                    n_state         = S_PUSH;
                end
            end
            // Push: drop when full, else sift the hole up
            S_PUSH: begin
                if (i_sts.heap_full) begin
                    n_state = r_ret;
                end else begin
                    o_cmd.push_start = 1'b1;
                    n_state          = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_sts.up_root) begin
                    o_cmd.heap_wr_ent = 1'b1;
                    n_state           = r_ret;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_ge) begin
                    o_cmd.heap_wr_ent = 1'b1;
                    n_state           = r_ret;
                end else begin
                    o_cmd.up_step = 1'b1;
                    n_state       = S_UP_CHK;
                end
            end
            // Look at the top: fail on an empty heap, stop on goal, else pop it
            S_TOP_RD: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_TOP_CHK;
            end
            S_TOP_CHK: begin
                if (i_sts.heap_empty) begin
                    n_state = S_FAIL;
                end else if (i_sts.top_is_goal) begin
                    o_cmd.succ = 1'b1;
                    n_state    = S_TR_CHK;
                end else begin
                    o_cmd.pop_start = 1'b1;
                    if (i_sts.heap_one) begin
                        n_state = S_DIR;
                    end else begin
                        o_cmd.rd_last = 1'b1;
                        n_state       = S_DN_LAST;
                    end
                end
            end
            // Sift the last entry down from the root
            S_DN_LAST: begin
                o_cmd.load_last = 1'b1;
                n_state         = S_DN_L;
            end
            S_DN_L: begin
                if (i_sts.l_out) begin
                    o_cmd.heap_wr_ent = 1'b1;
                    n_state           = S_DIR;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_DN_R;
                end
            end
            S_DN_R: begin
                o_cmd.rd_right = 1'b1;
                n_state        = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.dn_move) begin
                    o_cmd.dn_step = 1'b1;
                    n_state       = S_DN_L;
                end else begin
                    o_cmd.heap_wr_ent = 1'b1;
                    n_state           = S_DIR;
                end
            end
            // Walk the four neighbors
            S_DIR: begin
                if (i_sts.dir_done) begin
                    n_state = S_TOP_RD;
                end else begin
                    o_cmd.dir_rd = 1'b1;
                    n_state      = S_DIR_WALL;
                end
            end
            S_DIR_WALL: begin
                if (i_sts.nb_ok) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state     = S_RELAX;
                end else begin
                    o_cmd.dir_next = 1'b1;
                    n_state        = S_DIR;
                end
            end
            S_RELAX: begin
                o_cmd.dir_next = 1'b1;
                if (i_sts.better) begin
                    o_cmd.relax_upd = 1'b1;
                    n_ret           = S_DIR;
                    n_state         = S_PUSH;
                end else begin
                    n_state = S_DIR;
                end
            end
            // Emit the trace from goal back toward start
            S_TR_CHK: begin
                if (i_sts.tr_done) begin
                    n_state = S_TR_END;
                end else begin
                    o_cmd.prev_rd = 1'b1;
                    n_state       = S_TR_EMIT;
                end
            end
            S_TR_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_TRACE;
                    o_cmd.tr_step  = 1'b1;
                    n_state        = S_TR_CHK;
                end
            end
            S_TR_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_START;
                    n_state        = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_FAIL;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/grid_astar_path_search_top.sv]
// ============================================================================
// grid_astar_path_search_top
// A* path search on a 16 x 16 grid with walls, smoke and fire cells.
// ============================================================================
// A write request (tuser 0) stores one grid cell. A query request
// (tuser 1) runs an A* search from start to goal and returns the path cost and
// the trace from goal back to start, one result per cell, tlast on the start
// cell; a single result answers start equal to goal or an unreachable goal.
// One request is worked at a time. A search first clears its per-cell marks,
// one cell per cycle, then each expansion costs a pop (a left read, a right
// read and a compare per heap level) plus a direction step and a wall check per
// neighbor and a push (a parent read and a compare per heap level) for each
// improved neighbor, all bound by the single read port of the heap memory;
// trace output reads each cell's entry direction, then emits it when the sink is ready.
module grid_astar_path_search_top #(
    parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // cell_x, cell_y, cell_status, wall_east, wall_south,
    // start_x, start_y, goal_x, goal_y, count_smoke
    input  logic [31:0]                i_s_tdata,
    // req_type
    input  logic                       i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // found, total_cost, tile_x, tile_y
    output logic [23:0]                o_m_tdata,
    output logic                       o_m_tlast,
    input  logic                       i_cfg_wr_en,
    input  logic [gaps_pkg::LIM_W-1:0] i_cfg_wr_data
);
    import gaps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gaps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req_kind  (i_s_tuser),
        .o_req_ready (o_s_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gaps_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_data    (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_res_data    (o_m_tdata),
        .o_res_last    (o_m_tlast)
    );

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Grid path search testbench
// Loads grid cells and runs path queries against an in-bench A* predictor,
// checking cost and trace cells of every result, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gaps_pkg::*;

    typedef struct packed {
        logic       req;
        logic [3:0] cx, cy;
        logic [1:0] st;
        logic       we, ws;
        logic [3:0] sx, sy, gx, gy;
        logic       smoke;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [9:0] cost;
        logic [3:0] tx, ty;
        logic       last;
    } t_res;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_s_tvalid = 0, i_s_tuser = 0, i_m_tready = 0;
    logic [31:0] i_s_tdata = '0;
    logic        i_cfg_wr_en = 0;
    logic [5:0]  i_cfg_wr_data = '0;
    logic        o_s_tready, o_m_tvalid, o_m_tlast;
    logic [23:0] o_m_tdata;

    grid_astar_path_search_top u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    logic [1:0] grid_stat [256];
    logic [1:0] grid_wall [256];
    int         cost_of [256];
    bit         cost_ok [256];
    bit         done_mk [256];
    logic [1:0] came [256];
    int         hkey [$];
    int         hcost [$];
    int         lim_reg = 63;

    t_req pend_req [$];
    t_res want_res [$];
    int   errors = 0, results_seen = 0, queries_sent = 0, cycles = 0;
    bit   hold_sink = 0;

    function automatic int manh(int a, int b);
        int dx, dy;
        dx = (a % 16) - (b % 16);
        dy = (a / 16) - (b / 16);
        return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    endfunction

    function automatic void heap_add(int f, int c, int idx);
        int i, p, t;
        if (hkey.size() >= HEAP_DEPTH) return;
        hkey.push_back((f << 12) | idx);
        hcost.push_back(c);
        i = hkey.size() - 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hkey[i] >= hkey[p]) break;
            t = hkey[i]; hkey[i] = hkey[p]; hkey[p] = t;
            t = hcost[i]; hcost[i] = hcost[p]; hcost[p] = t;
            i = p;
        end
    endfunction

    function automatic void heap_take(output int idx, output int c);
        int i, l, r, m, t, n;
        idx = hkey[0] & 'hfff;
        c = hcost[0];
        hkey[0] = hkey[$];
        hcost[0] = hcost[$];
        void'(hkey.pop_back());
        void'(hcost.pop_back());
        n = hkey.size();
        i = 0;
        forever begin
            l = 2 * i + 1; r = l + 1; m = i;
            if (l < n && hkey[l] < hkey[m]) m = l;
            if (r < n && hkey[r] < hkey[m]) m = r;
            if (m == i) break;
            t = hkey[i]; hkey[i] = hkey[m]; hkey[m] = t;
            t = hcost[i]; hcost[i] = hcost[m]; hcost[m] = t;
            i = m;
        end
    endfunction

    function automatic void try_cell(int nb, int base, logic [1:0] dir, int g, bit smk);
        int c;
        if (done_mk[nb]) return;
        c = base + 1;
        if (grid_stat[nb] == STAT_FIRE) c++;
        if (smk && grid_stat[nb] == STAT_SMOKE) c++;
        if (c > 1023) c = 1023;
        if (!cost_ok[nb] || c < cost_of[nb]) begin
            cost_ok[nb] = 1;
            cost_of[nb] = c;
            came[nb] = dir;
            heap_add(c + manh(nb, g), c, nb);
        end
    endfunction

    function automatic void add_res(bit f, int c, int idx, bit l);
        t_res r;
        r.found = f; r.cost = c[9:0]; r.tx = 4'(idx % 16); r.ty = 4'(idx / 16); r.last = l;
        want_res.push_back(r);
    endfunction

    // compute the expected answer of one request
    function automatic void predict_path(t_req q);
        int s, g, c, cc, x, y, t, k, lim, gcost;
        bit ok;
        if (q.req == REQ_WRITE) begin
            grid_stat[{q.cy, q.cx}] = q.st;
            grid_wall[{q.cy, q.cx}] = {q.ws, q.we};
            return;
        end
        queries_sent++;
        s = int'({q.sy, q.sx});
        g = int'({q.gy, q.gx});
        if (s == g) begin
            add_res(1, 0, s, 1);
            return;
        end
        for (int i = 0; i < 256; i++) begin
            cost_ok[i] = 0; done_mk[i] = 0;
        end
        hkey.delete(); hcost.delete();
        ok = 0;
        heap_add(manh(s, g), 0, s);
        while (hkey.size() > 0) begin
            heap_take(c, cc);
            done_mk[c] = 1;
            x = c % 16; y = c / 16;
            if (x < 15 && !grid_wall[c][0]) try_cell(c + 1, cc, DIR_FROM_WEST, g, q.smoke);
            if (x > 0 && !grid_wall[c-1][0]) try_cell(c - 1, cc, DIR_FROM_EAST, g, q.smoke);
            if (y < 15 && !grid_wall[c][1]) try_cell(c + 16, cc, DIR_FROM_NORTH, g, q.smoke);
            if (y > 0 && !grid_wall[c-16][1]) try_cell(c - 16, cc, DIR_FROM_SOUTH, g, q.smoke);
            if (hkey.size() > 0 && (hkey[0] & 'hfff) == g) begin
                ok = 1;
                break;
            end
        end
        if (!ok) begin
            add_res(0, 0, s, 1);
            return;
        end
        lim = (lim_reg < 1) ? 1 : lim_reg;
        gcost = hcost[0];
        t = g; k = 0;
        while (t != s && k < lim) begin
            x = t % 16; y = t / 16;
            add_res(1, gcost, t, 0);
            k++;
            if (came[t] == DIR_FROM_WEST && x > 0) t = t - 1;
            else if (came[t] == DIR_FROM_EAST && x < 15) t = t + 1;
            else if (came[t] == DIR_FROM_NORTH && y > 0) t = t - 16;
            else if (came[t] == DIR_FROM_SOUTH && y < 15) t = t + 16;
        end
        add_res(1, gcost, s, 1);
    endfunction

    function automatic t_req mk_write(int x, int y, int st, bit e, bit s);
        t_req r = '0;
        r.req = REQ_WRITE; r.cx = 4'(x); r.cy = 4'(y); r.st = 2'(st); r.we = e; r.ws = s;
        return r;
    endfunction

    function automatic t_req mk_query(int sx, int sy, int gx, int gy, bit smk);
        t_req r;
        r = t_req'(30'($urandom));  // random don't-care write fields
        r.req = REQ_QUERY; r.sx = 4'(sx); r.sy = 4'(sy); r.gx = 4'(gx); r.gy = 4'(gy);
        r.smoke = smk;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    endfunction

    // pack the request fields into tdata, cell_x in the lowest bits
    function automatic logic [31:0] pack_req(t_req r);
        return {3'd0, r.smoke, r.gy, r.gx, r.sy, r.sx, r.ws, r.we, r.st, r.cy, r.cx};
    endfunction

    // driver: offer pending requests with random gaps
    int  drv_gap = 0;
    bit  drv_free_run = 0;
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            pend_req.delete(0);
            drv_gap = drv_free_run ? 0 : gap_len();
        end
        if (!i_rst_n || !(i_s_tvalid && !o_s_tready)) begin
            if (drv_gap > 0) begin
                drv_gap--;
                i_s_tvalid <= 0;
            end else if (pend_req.size() > 0 && i_rst_n) begin
                i_s_tvalid <= 1;
                i_s_tuser  <= pend_req[0].req;
                i_s_tdata  <= pack_req(pend_req[0]);
            end else begin
                i_s_tvalid <= 0;
            end
        end
    end

    // monitor: accept results and compare with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (want_res.size() == 0) begin
                errors++;
                $error("unexpected result %h last %b", o_m_tdata, o_m_tlast);
            end else begin
                e = want_res.pop_front();
                if (o_m_tdata[0] !== e.found) begin
                    errors++; $error("found exp %0d got %0d", e.found, o_m_tdata[0]);
                end
                if (o_m_tdata[10:1] !== e.cost) begin
                    errors++; $error("total_cost exp %0d got %0d", e.cost, o_m_tdata[10:1]);
                end
                if (o_m_tdata[14:11] !== e.tx) begin
                    errors++; $error("tile_x exp %0d got %0d", e.tx, o_m_tdata[14:11]);
                end
                if (o_m_tdata[18:15] !== e.ty) begin
                    errors++; $error("tile_y exp %0d got %0d", e.ty, o_m_tdata[18:15]);
                end
                if (o_m_tlast !== e.last) begin
                    errors++; $error("last exp %0d got %0d", e.last, o_m_tlast);
                end
            end
        end
        i_m_tready <= hold_sink ? 1'b0 : ($urandom_range(0, 9) < 7);
        if (cycles > 20000000) begin
            $display("[grid_astar_path_search_top] ERROR");
            $finish;
        end
    end

    // queue a request and predict its answer
    task automatic send(t_req r);
        pend_req.push_back(r);
        predict_path(r);
    endtask

    task automatic drain();
        wait (pend_req.size() == 0 && want_res.size() == 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_limit(int v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= 6'(v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 0;
        lim_reg = v;
    endtask

    function automatic t_req rand_item();
        int p = $urandom_range(0, 99);
        if (p < 55)
            return mk_write($urandom_range(0, 15), $urandom_range(0, 15),
                            ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 3),
                            $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        return mk_query($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
    endfunction

    initial begin
        for (int i = 0; i < 256; i++) begin
            grid_stat[i] = 0; grid_wall[i] = 0; came[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // directed: extremes, statuses, walls, corner queries
        send(mk_query(0, 0, 15, 15, 0));
        send(mk_query(15, 15, 0, 0, 1));
        send(mk_query(7, 7, 7, 7, 0));
        send(mk_write(1, 0, 1, 0, 0));
        send(mk_write(0, 1, 2, 0, 0));
        send(mk_write(2, 2, 3, 1, 1));
        send(mk_write(15, 15, 2, 1, 1));
        send(mk_query(0, 0, 2, 2, 1));
        send(mk_query(0, 0, 2, 2, 0));
        send(mk_query(2, 2, 3, 3, 0));
        // wall off the corner cell 0,0: unreachable goal
        send(mk_write(0, 0, 0, 1, 1));
        send(mk_query(5, 5, 0, 0, 0));
        send(mk_write(0, 0, 0, 0, 0));
        send(mk_query(0, 15, 15, 0, 1));
        drain();
        set_limit(1);
        send(mk_query(0, 0, 15, 15, 0));
        send(mk_query(3, 9, 12, 1, 1));
        drain();
        set_limit(0);
        send(mk_query(15, 0, 0, 15, 0));
        drain();

        // long sink stall while the source keeps sending
        set_limit(63);
        fork
            begin
                hold_sink = 1;
                repeat (30000) @(posedge i_clk);
                hold_sink = 0;
            end
        join_none
        drv_free_run = 1;
        for (int i = 0; i < 6; i++) send(mk_query(0, i, 15, 15 - i, i[0]));
        drain();
        drv_free_run = 0;

        // random phases at several limits
        for (int ph = 0; ph < 4; ph++) begin
            set_limit(ph == 0 ? 63 : ph == 1 ? 5 : ph == 2 ? 30 : 2);
            for (int i = 0; i < 30; i++) send(rand_item());
            drain();
        end
        repeat (100) @(posedge i_clk);

        $display("covered %0d queries, %0d results, limits 0 to 63, long sink stall",
                 queries_sent, results_seen);
        if (errors == 0 && want_res.size() == 0)
            $display("[grid_astar_path_search_top] OK");
        else
            $display("[grid_astar_path_search_top] ERROR");
        $finish;
    end
endmodule

[files.f]
hw/rtl/gaps_pkg.sv
hw/rtl/gaps_ram.sv
hw/rtl/gaps_dp.sv
hw/rtl/gaps_ctrl.sv
hw/rtl/grid_astar_path_search_top.sv
verif/tb_top.sv
